[hw/rtl/bba_pkg.sv]
// ---------------------------------------------------------------------------
// Bitmap block allocator package
// Shared widths, reset values and result codes.
// ---------------------------------------------------------------------------
package bba_pkg;

   localparam int NUM_BLOCKS_DEFAULT = 1024;
   localparam int BLOCK_COUNT_RESET  = 1024;

   localparam int WORD_BITS = 32;   // blocks per bitmap word
   localparam int IDX_W     = 10;   // block_index / granted_block
   localparam int CNT_W     = 11;   // block_count and the two totals
   localparam int STATUS_W  = 2;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 2'd0,
      ST_NO_FREE      = 2'd1,
      ST_OUT_OF_RANGE = 2'd2,
      ST_ALREADY_FREE = 2'd3
   } status_type;

   typedef enum logic {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } action_type;

endpackage

[hw/rtl/bba_ram.sv]
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module bba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                          clock,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/bitmap_block_allocator.sv]
// ---------------------------------------------------------------------------
// Bitmap block allocator
// First-fit allocator over a used/free bitmap held in a RAM of 32-bit words.
// ---------------------------------------------------------------------------
// One request is handled at a time. An allocate reads the bitmap one word
// per cycle from word 0 and stops at the first word with a free managed
// block; the single RAM read port sets that pace. A free reads only the
// word that holds its block, and a request that fails on the counters or
// on the index range goes to its result without reading the bitmap. The
// result sits in an output register, so a new request is taken while it
// waits. There is no clearing pass: after reset or a block_count write a
// fill mark restarts at zero and words at or above it read as all free, so
// requests are taken right away.
// ---------------------------------------------------------------------------
module bitmap_block_allocator #(
   parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [9:0] block_index, [15:10] zero
   input  logic        req_tuser,    // [0] action

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [9:0] granted_block, [20:10] free_total,
                                     // [31:21] used_total
   output logic [1:0]  rsp_tuser,    // [1:0] status

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_data      // block_count
);

   localparam int MAP_WORDS = (NUM_BLOCKS + bba_pkg::WORD_BITS - 1) / bba_pkg::WORD_BITS;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int HW_W      = $clog2(MAP_WORDS + 1);
   localparam int RstLimit  = (bba_pkg::BLOCK_COUNT_RESET > NUM_BLOCKS) ?
                              NUM_BLOCKS : bba_pkg::BLOCK_COUNT_RESET;
   localparam logic [31:0] NumBlocks32 = 32'(NUM_BLOCKS);
   localparam int CW = bba_pkg::CNT_W;
   localparam int IW = bba_pkg::IDX_W;
   localparam int WB = bba_pkg::WORD_BITS;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_START = 4'b0010,
      S_EVAL  = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic                     action_ff, action_in;
   logic [IW-1:0]            blk_ff, blk_in;
   logic [AW-1:0]            word_ff, word_in;
   logic [HW_W-1:0]          hw_ff, hw_in;
   logic [CW-1:0]            limit_ff, limit_in;
   logic [CW-1:0]            free_ff, free_in;
   logic [CW-1:0]            used_ff, used_in;
   bba_pkg::status_type      res_status_ff, res_status_in;
   logic [IW-1:0]            res_grant_ff, res_grant_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;
   logic [IW-1:0]            rsp_grant_ff, rsp_grant_in;
   logic [CW-1:0]            rsp_free_ff, rsp_free_in;
   logic [CW-1:0]            rsp_used_ff, rsp_used_in;

   // RAM side
   logic                     rd_en;
   logic [AW-1:0]            rd_addr;
   logic [WB-1:0]            ram_q;
   logic                     wr_en;
   logic [WB-1:0]            wr_data;

   // word evaluation
   logic [WB-1:0]            cur_word;
   logic [31:0]              base32;
   logic [31:0]              rem32;
   logic [WB-1:0]            valid_mask;
   logic [WB-1:0]            avail;
   logic [4:0]               hit_pos;
   logic                     more_words;
   logic                     alloc_hit;
   logic [31:0]              grant32;
   logic [31:0]              blk_word32;
   logic [4:0]               blk_bit;
   logic                     req_beat;
   logic                     csr_beat;

   assign req_beat = req_tvalid && req_tready;
   assign csr_beat = csr_valid && csr_ready;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;

   bba_ram #(
      .WIDTH (WB),
      .DEPTH (MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q),
      .wr_en   (wr_en),
      .wr_addr (word_ff),
      .wr_data (wr_data)
   );

   // words at or above the fill mark were never written since the last clear
   assign cur_word = (32'(word_ff) < 32'(hw_ff)) ? ram_q : '0;

   assign base32     = 32'(word_ff) << 5;
   assign rem32      = 32'(limit_ff) - base32;
   assign valid_mask = (rem32 >= 32'(WB)) ? '1 : ((32'd1 << rem32[4:0]) - 32'd1);
   assign avail      = ~cur_word & valid_mask;
   assign more_words = (base32 + 32'(WB)) < 32'(limit_ff);
   assign alloc_hit  = (state_ff == S_EVAL) && (action_ff == bba_pkg::ACT_ALLOC) &&
                       (avail != '0);
   assign grant32    = base32 | 32'(hit_pos);
   assign blk_word32 = 32'(blk_ff) >> 5;
   assign blk_bit    = blk_ff[4:0];

   // lowest free bit
   always_comb begin
      hit_pos = '0;
      for (int b = WB - 1; b >= 0; b--) begin
         if (avail[b]) begin
            hit_pos = 5'(b);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      blk_in        = blk_ff;
      word_in       = word_ff;
      hw_in         = hw_ff;
      limit_in      = limit_ff;
      free_in       = free_ff;
      used_in       = used_ff;
      res_status_in = res_status_ff;
      res_grant_in  = res_grant_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_grant_in  = rsp_grant_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_used_in   = rsp_used_ff;
      rd_en         = 1'b0;
      rd_addr       = word_ff;
      wr_en         = 1'b0;
      wr_data       = cur_word;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               action_in = req_tuser;
               blk_in    = req_tdata[IW-1:0];
               state_in  = S_START;
            end
         end
         S_START: begin
            res_grant_in = '0;
            if (action_ff == bba_pkg::ACT_ALLOC) begin
               if (free_ff == '0) begin
                  res_status_in = bba_pkg::ST_NO_FREE;
                  state_in      = S_DONE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  word_in  = '0;
                  state_in = S_EVAL;
               end
            end else begin
               if (32'(blk_ff) >= 32'(limit_ff)) begin
                  res_status_in = bba_pkg::ST_OUT_OF_RANGE;
                  state_in      = S_DONE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = blk_word32[AW-1:0];
                  word_in  = blk_word32[AW-1:0];
                  state_in = S_EVAL;
               end
            end
         end
         S_EVAL: begin
            if (action_ff == bba_pkg::ACT_ALLOC) begin
               if (avail != '0) begin
                  wr_en         = 1'b1;
                  wr_data       = cur_word | (WB'(1) << hit_pos);
                  free_in       = free_ff - CW'(1);
                  used_in       = used_ff + CW'(1);
                  res_grant_in  = grant32[IW-1:0];
                  res_status_in = bba_pkg::ST_OK;
                  state_in      = S_DONE;
               end else if (more_words) begin
                  rd_en   = 1'b1;
                  rd_addr = word_ff + AW'(1);
                  word_in = word_ff + AW'(1);
               end else begin
                  res_status_in = bba_pkg::ST_NO_FREE;
                  state_in      = S_DONE;
               end
            end else begin
               if (!cur_word[blk_bit]) begin
                  res_status_in = bba_pkg::ST_ALREADY_FREE;
               end else begin
                  wr_en         = 1'b1;
                  wr_data       = cur_word & ~(WB'(1) << blk_bit);
                  free_in       = free_ff + CW'(1);
                  if (used_ff != '0) begin
                     used_in = used_ff - CW'(1);
                  end
                  res_status_in = bba_pkg::ST_OK;
               end
               state_in = S_DONE;
            end
            // allocation fills the map as a prefix of words
            if (wr_en && (32'(word_ff) == 32'(hw_ff))) begin
               hw_in = hw_ff + HW_W'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_grant_in  = res_grant_ff;
               rsp_free_in   = free_ff;
               rsp_used_in   = used_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // block_count write re-initializes the pool
      if (csr_beat) begin
         limit_in = (32'(csr_data) > NumBlocks32) ? NumBlocks32[CW-1:0] : csr_data;
         free_in  = limit_in;
         used_in  = '0;
         hw_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hw_ff        <= '0;
         limit_ff     <= CW'(RstLimit);
         free_ff      <= CW'(RstLimit);
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hw_ff        <= hw_in;
         limit_ff     <= limit_in;
         free_ff      <= free_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      blk_ff        <= blk_in;
      word_ff       <= word_in;
      res_status_ff <= res_status_in;
      res_grant_ff  <= res_grant_in;
      rsp_status_ff <= rsp_status_in;
      rsp_grant_ff  <= rsp_grant_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_used_ff   <= rsp_used_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_used_ff, rsp_free_ff, rsp_grant_ff};

   // free and used always account for the whole managed pool
   a_pool_balance: assert property (@(posedge clock) disable iff (reset)
      (12'(free_ff) + 12'(used_ff)) == 12'(limit_ff))
      else $error("free/used counters out of balance");

   a_grant_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != bba_pkg::ST_OK)) |-> (rsp_tdata[IW-1:0] == '0))
      else $error("granted block nonzero on failed request");

   a_alloc_counts: assert property (@(posedge clock) disable iff (reset)
      (alloc_hit && !csr_beat) |=> (used_ff == $past(used_ff) + CW'(1)))
      else $error("used count did not advance on a grant");

endmodule
